// File: hdl/ddf_pkg.sv
// Shared types and constants for the decimal digit formatter.
package ddf_pkg;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int VALUE_BITS_DEF = 32;

    localparam int COUNT_W     = 4;
    localparam int START_X_W   = 7;
    localparam int START_Y_W   = 6;
    localparam int CODE_W      = 6;
    localparam int GLYPH_X_W   = 8;
    localparam int SIZE_W      = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int DIGIT_W     = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FG_COLOR  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_COLOR  = 2'd2;

    localparam logic [SIZE_W-1:0] CHAR_SIZE_RST = 5'd12;

    localparam logic [CODE_W-1:0] CHAR_SPACE = 6'd32;
    localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

    // Field description handed from the input side to the output sequencer.
    typedef struct packed {
        logic                 load;
        logic [COUNT_W-1:0]   count;
        logic [START_X_W-1:0] start_x;
        logic [START_Y_W-1:0] start_y;
    } t_field_cmd;

endpackage

// File: hdl/ddf_bcd_conv.sv
// Bit-serial shift-and-add-3 binary to BCD converter.
module ddf_bcd_conv #(
    parameter int VALUE_BITS = ddf_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = ddf_pkg::MAX_DIGITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [VALUE_BITS-1:0]                     i_value,
    output logic                                      o_busy,
    output logic                                      o_done,
    output logic [MAX_DIGITS*ddf_pkg::DIGIT_W-1:0]    o_bcd
);
    import ddf_pkg::*;

    localparam int BCD_W = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      w_adj;
    logic [BCD_W-1:0]      n_bcd;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    // Every digit that would reach ten or more when doubled is corrected first.
    // The carry out of the top digit is dropped, which keeps the value modulo 10^N.
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (r_bcd[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                w_adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                w_adj[k*DIGIT_W +: DIGIT_W] = r_bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
        n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// File: hdl/ddf_field_emit.sv
// Output sequencer: one character per position, most significant first.
module ddf_field_emit #(
    parameter int MAX_DIGITS = ddf_pkg::MAX_DIGITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ddf_pkg::t_field_cmd                     i_cmd,
    input  logic [MAX_DIGITS*ddf_pkg::DIGIT_W-1:0]  i_bcd,
    input  logic [ddf_pkg::SIZE_W-1:0]              i_char_size,
    output logic                                    o_idle,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [ddf_pkg::CODE_W-1:0]              o_char_code,
    output logic [ddf_pkg::GLYPH_X_W-1:0]           o_glyph_x,
    output logic [ddf_pkg::START_Y_W-1:0]           o_glyph_y,
    output logic                                    o_last
);
    import ddf_pkg::*;

    localparam int N_W   = $clog2(MAX_DIGITS + 1);
    localparam int POS_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                 r_busy;
    logic [POS_W-1:0]     r_pos;
    logic                 r_shown;
    logic [GLYPH_X_W-1:0] r_x;
    logic [START_Y_W-1:0] r_y;
    logic                 r_valid;
    logic [CODE_W-1:0]    r_code;
    logic [GLYPH_X_W-1:0] r_out_x;
    logic                 r_last;

    logic [N_W-1:0]       w_n;
    logic [DIGIT_W-1:0]   w_digit;
    logic                 w_is_last;
    logic                 w_emit;
    logic [CODE_W-1:0]    n_code;
    logic [GLYPH_X_W-1:0] w_step;

    // Counts above the field capacity are clipped to it.
    always_comb begin
        if (32'(i_cmd.count) > 32'(MAX_DIGITS)) begin
            w_n = N_W'(MAX_DIGITS);
        end else begin
            w_n = N_W'(i_cmd.count);
        end
    end

    assign w_digit   = i_bcd[r_pos*DIGIT_W +: DIGIT_W];
    assign w_is_last = (r_pos == '0);
    assign w_emit    = r_busy && (!r_valid || i_ready);
    assign w_step    = GLYPH_X_W'(i_char_size >> 1);

    // A leading zero is blanked until a nonzero digit or the last position.
    always_comb begin
        if (!r_shown && !w_is_last && (w_digit == '0)) begin
            n_code = CHAR_SPACE;
        end else begin
            n_code = CHAR_ZERO + CODE_W'(w_digit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (w_n != '0)) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_is_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos   <= POS_W'(w_n - 1'b1);
            r_x     <= GLYPH_X_W'(i_cmd.start_x);
            r_y     <= i_cmd.start_y;
            r_shown <= 1'b0;
        end else if (w_emit) begin
            r_pos   <= r_pos - 1'b1;
            r_x     <= r_x + w_step;
            r_shown <= r_shown || (n_code != CHAR_SPACE);
        end
        if (w_emit) begin
            r_code  <= n_code;
            r_out_x <= r_x;
            r_last  <= w_is_last;
        end
    end

    assign o_idle      = !r_busy && !r_valid;
    assign o_valid     = r_valid;
    assign o_char_code = r_code;
    assign o_glyph_x   = r_out_x;
    assign o_glyph_y   = r_y;
    assign o_last      = r_last;

endmodule

// File: hdl/decimal_digit_formatter_unit.sv
// The first character follows the input transaction through conversion, hand-off to the
// sequencer and the output register, then one per cycle unless stalled.
// A new number is accepted only once the previous field has been fully emitted; the
// bit-serial converter shifts in one value bit per cycle.
// Reset (synchronous, active low) idles both units and sets char_size to 12.
// Color registers accept writes but hold nothing, as no port carries them.
module decimal_digit_formatter_unit #(
    parameter int MAX_DIGITS = ddf_pkg::MAX_DIGITS_DEF,
    parameter int VALUE_BITS = ddf_pkg::VALUE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ddf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ddf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [VALUE_BITS-1:0]                i_value,
    input  logic [ddf_pkg::COUNT_W-1:0]          i_digit_count,
    input  logic [ddf_pkg::START_X_W-1:0]        i_start_x,
    input  logic [ddf_pkg::START_Y_W-1:0]        i_start_y,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [ddf_pkg::CODE_W-1:0]           o_char_code,
    output logic [ddf_pkg::GLYPH_X_W-1:0]        o_glyph_x,
    output logic [ddf_pkg::START_Y_W-1:0]        o_glyph_y,
    output logic                                 o_last
);
    import ddf_pkg::*;

    logic [SIZE_W-1:0]               r_char_size;
    logic [COUNT_W-1:0]              r_count;
    logic [START_X_W-1:0]            r_start_x;
    logic [START_Y_W-1:0]            r_start_y;
    logic                            w_accept;
    logic                            w_conv_busy;
    logic                            w_conv_done;
    logic                            w_emit_idle;
    logic [MAX_DIGITS*DIGIT_W-1:0]   w_bcd;
    t_field_cmd                      w_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !w_conv_busy && !w_conv_done && w_emit_idle;
    assign w_accept    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_size <= CHAR_SIZE_RST;
        end else if (i_cfg_valid && (i_cfg_index == REG_CHAR_SIZE)) begin
            r_char_size <= i_cfg_data[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_count   <= i_digit_count;
            r_start_x <= i_start_x;
            r_start_y <= i_start_y;
        end
    end

    ddf_bcd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_value),
        .o_busy  (w_conv_busy),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    always_comb begin
        w_cmd.load    = w_conv_done;
        w_cmd.count   = r_count;
        w_cmd.start_x = r_start_x;
        w_cmd.start_y = r_start_y;
    end

    ddf_field_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_bcd       (w_bcd),
        .i_char_size (r_char_size),
        .o_idle      (w_emit_idle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_glyph_x   (o_glyph_x),
        .o_glyph_y   (o_glyph_y),
        .o_last      (o_last)
    );

    // One number at a time: a new transaction waits until the field is finished.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("input accepted while a number is in flight");

    // Characters only leave once the conversion has completed.
    a_no_output_while_converting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_conv_busy)
        else $error("output valid during conversion");

    // The final position always shows a digit.
    a_last_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_char_code != CHAR_SPACE))
        else $error("last position blanked");

    // The converter done pulse lasts one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |=> !w_conv_done)
        else $error("converter done held");

endmodule

// File: tb/ddf_tb_pkg.sv
// Scoreboard class and glyph type for the decimal digit formatter testbench.
package ddf_tb_pkg;
    import ddf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]    code;
        logic [GLYPH_X_W-1:0] x;
        logic [START_Y_W-1:0] y;
        logic                 is_last;
    } t_glyph;

    class digit_field_tracker;
        logic [SIZE_W-1:0]     char_size;
        logic [CFG_DATA_W-1:0] fg_color;
        logic [CFG_DATA_W-1:0] bg_color;
        t_glyph                pending_glyphs[$];
        int                    mismatches;
        int                    numbers_seen;
        int                    empty_fields;
        int                    glyphs_checked;

        function new();
            char_size      = CHAR_SIZE_RST;
            fg_color       = 8'd255;
            bg_color       = 8'd0;
            mismatches     = 0;
            numbers_seen   = 0;
            empty_fields   = 0;
            glyphs_checked = 0;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $time, what);
        endfunction

        function void apply_register(logic [CFG_INDEX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_CHAR_SIZE: char_size = data[SIZE_W-1:0];
                REG_FG_COLOR:  fg_color  = data;
                REG_BG_COLOR:  bg_color  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_glyphs.size();
        endfunction

        // Formats one accepted number into the glyphs it should produce.
        function void note_number(logic [VALUE_BITS_DEF-1:0] value,
                                  logic [COUNT_W-1:0] count,
                                  logic [START_X_W-1:0] sx,
                                  logic [START_Y_W-1:0] sy);
            logic [DIGIT_W-1:0]        digit_of_weight [MAX_DIGITS_DEF];
            logic [VALUE_BITS_DEF-1:0] rest;
            logic [GLYPH_X_W-1:0]      step;
            logic                      shown;
            int                        n;
            t_glyph                    g;
            rest = value;
            for (int k = 0; k < MAX_DIGITS_DEF; k++) begin
                digit_of_weight[k] = DIGIT_W'(rest % 10);
                rest = rest / 10;
            end
            n = (count > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : int'(count);
            step = GLYPH_X_W'(char_size >> 1);
            shown = 1'b0;
            numbers_seen++;
            if (n == 0)
                empty_fields++;
            for (int i = 0; i < n; i++) begin
                g.is_last = (i == n - 1);
                // Leading zeros stay blank, but the final position always shows a digit.
                if (!shown && !g.is_last && digit_of_weight[n-1-i] == 0) begin
                    g.code = CHAR_SPACE;
                end else begin
                    shown = 1'b1;
                    g.code = CHAR_ZERO + digit_of_weight[n-1-i];
                end
                g.x = GLYPH_X_W'(sx + step * i);
                g.y = sy;
                pending_glyphs.push_back(g);
            end
        endfunction

        function void check_glyph(logic [CODE_W-1:0] code, logic [GLYPH_X_W-1:0] x,
                                  logic [START_Y_W-1:0] y, logic is_last);
            t_glyph want;
            glyphs_checked++;
            if (pending_glyphs.size() == 0) begin
                report($sformatf("glyph %0d (code %0d at %0d,%0d) with nothing outstanding",
                                 glyphs_checked, code, x, y));
                return;
            end
            want = pending_glyphs.pop_front();
            if (code !== want.code)
                report($sformatf("glyph %0d char_code %0d, want %0d",
                                 glyphs_checked, code, want.code));
            if (x !== want.x)
                report($sformatf("glyph %0d glyph_x %0d, want %0d", glyphs_checked, x, want.x));
            if (y !== want.y)
                report($sformatf("glyph %0d glyph_y %0d, want %0d", glyphs_checked, y, want.y));
            if (is_last !== want.is_last)
                report($sformatf("glyph %0d last %0b, want %0b",
                                 glyphs_checked, is_last, want.is_last));
        endfunction
    endclass

endpackage

// File: tb/testbench.sv
// Top-level testbench for the decimal digit formatter unit.
module testbench;
    import ddf_pkg::*;
    import ddf_tb_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = VALUE_BITS_DEF + 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int NUM_PHASES       = 7;
    localparam int RANDOM_PER_PHASE = 56;
    localparam int HOLD_PHASE       = 3;
    localparam int CALM_PHASE       = 2;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_valid   = 1'b0;
    logic [CFG_INDEX_W-1:0]      i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data    = '0;
    logic                        i_valid       = 1'b0;
    logic [VALUE_BITS_DEF-1:0]   i_value       = '0;
    logic [COUNT_W-1:0]          i_digit_count = '0;
    logic [START_X_W-1:0]        i_start_x     = '0;
    logic [START_Y_W-1:0]        i_start_y     = '0;
    logic                        i_ready       = 1'b0;
    logic                        o_cfg_ready;
    logic                        o_ready;
    logic                        o_valid;
    logic [CODE_W-1:0]           o_char_code;
    logic [GLYPH_X_W-1:0]        o_glyph_x;
    logic [START_Y_W-1:0]        o_glyph_y;
    logic                        o_last;

    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;
    bit hold_request  = 1'b0;
    int config_writes = 0;

    digit_field_tracker tracker;

    decimal_digit_formatter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_code   (o_char_code),
        .o_glyph_x     (o_glyph_x),
        .o_glyph_y     (o_glyph_y),
        .o_last        (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_BITS_DEF-1:0] random_value();
        logic [VALUE_BITS_DEF-1:0] v;
        int k;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 9);
            1: v = $urandom_range(0, 99999);
            2: begin
                // A single nonzero digit followed by zeros.
                v = $urandom_range(1, 4);
                k = $urandom_range(0, 9);
                repeat (k) v = v * 10;
            end
            3: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
            4: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] random_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 14)
            return COUNT_W'($urandom_range(11, 15));
        return COUNT_W'($urandom_range(1, 10));
    endfunction

    task automatic send_number(input logic [VALUE_BITS_DEF-1:0] value,
                               input logic [COUNT_W-1:0] count,
                               input logic [START_X_W-1:0] sx,
                               input logic [START_Y_W-1:0] sy);
        i_valid       <= 1'b1;
        i_value       <= value;
        i_digit_count <= count;
        i_start_x     <= sx;
        i_start_y     <= sy;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_number(value, count, sx, sy);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int how_many);
        for (int n = 0; n < how_many; n++) begin
            send_number(random_value(), random_count(), START_X_W'($urandom_range(0, 127)),
                        START_Y_W'($urandom_range(0, 63)));
            sender_gap(sender_calm ? 0 : pick_gap());
        end
    endtask

    // An empty field produces nothing, so the block may still be converting it.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.apply_register(index, data);
        i_cfg_valid <= 1'b0;
        config_writes++;
        @(posedge i_clk);
    endtask

    task automatic send_directed();
        send_number(32'd0, 4'd1, 7'd0, 6'd0);
        send_number(32'd0, 4'd10, 7'd127, 6'd63);
        sender_gap(pick_gap());
        send_number(32'hFFFF_FFFF, 4'd10, 7'd0, 6'd63);
        send_number(32'hFFFF_FFFF, 4'd3, 7'd127, 6'd0);
        send_number(32'd1000000000, 4'd10, 7'd5, 6'd7);
        sender_gap(pick_gap());
        send_number(32'd1000000000, 4'd9, 7'd5, 6'd7);
        send_number(32'd1234567890, 4'd15, 7'd1, 6'd2);
        send_number(32'd987654321, 4'd11, 7'd90, 6'd33);
        send_number(32'd42, 4'd0, 7'd10, 6'd10);
        sender_gap(pick_gap());
        send_number(32'd100, 4'd5, 7'd20, 6'd40);
        send_number(32'd5, 4'd1, 7'd127, 6'd63);
        send_number(32'd10, 4'd2, 7'd64, 6'd1);
        send_number(32'd99, 4'd2, 7'd3, 6'd62);
        sender_gap(pick_gap());
        send_number(32'd1, 4'd10, 7'd127, 6'd63);
        send_number(32'h1234_5678, 4'd8, 7'd64, 6'd32);
        send_number(32'h8000_0000, 4'd10, 7'h55, 6'h2A);
        send_number(32'h7FFF_FFFF, 4'd10, 7'h2A, 6'h15);
        send_number(32'd0, 4'd0, 7'd0, 6'd0);
        send_number(32'd4000000000, 4'd10, 7'd100, 6'd50);
    endtask

    initial begin : main
        logic [SIZE_W-1:0] size_plan [NUM_PHASES];
        logic [CFG_DATA_W-1:0] fg_plan [NUM_PHASES];
        logic [CFG_DATA_W-1:0] bg_plan [NUM_PHASES];
        tracker = new();
        size_plan = '{5'd12, 5'd0, 5'd1, 5'd31, 5'd24, 5'd7, 5'd12};
        fg_plan   = '{8'd255, 8'd0, 8'd255, 8'h5A, 8'hA5, 8'd0, 8'd255};
        bg_plan   = '{8'd0, 8'd255, 8'd0, 8'hA5, 8'h5A, 8'd255, 8'd0};
        size_plan[NUM_PHASES-1] = SIZE_W'($urandom_range(0, 31));
        fg_plan[NUM_PHASES-1]   = CFG_DATA_W'($urandom);
        bg_plan[NUM_PHASES-1]   = CFG_DATA_W'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        sender_gap(pick_gap());
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_for_drain();
                // Random upper bits check that only the low five bits set the size.
                write_config(REG_CHAR_SIZE, {3'($urandom), size_plan[phase]});
                write_config(REG_FG_COLOR, fg_plan[phase]);
                write_config(REG_BG_COLOR, bg_plan[phase]);
                write_config(REG_UNUSED, CFG_DATA_W'($urandom));
            end
            sender_calm   = (phase == CALM_PHASE) || (phase == HOLD_PHASE);
            receiver_calm = (phase == CALM_PHASE);
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            send_random(RANDOM_PER_PHASE);
        end

        wait_for_drain();
        $display("Covered %0d numbers (%0d empty fields) and %0d glyphs",
                 tracker.numbers_seen, tracker.empty_fields, tracker.glyphs_checked);
        $display("across %0d font sizes with %0d register writes, %0d mismatches",
                 NUM_PHASES, config_writes, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("** decimal_digit_formatter_unit: PASSED **");
        else
            $display("** decimal_digit_formatter_unit: FAILED **");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off so the block backs up.
    initial begin : receiver
        int stall_left;
        int run_left;
        bit hold_taken;
        stall_left = 0;
        run_left   = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left == 0 && run_left == 0) begin
                stall_left = receiver_calm ? 0 : pick_gap();
                run_left   = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                run_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_glyph(o_char_code, o_glyph_x, o_glyph_y, o_last);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transaction for %0d cycles, %0d glyphs outstanding",
                 WATCHDOG_LIMIT, tracker.pending());
        $display("** decimal_digit_formatter_unit: FAILED **");
        $finish;
    end

endmodule
